// File: rtl/amge_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amge_pkg: shared types and constants for the accelerometer magnitude gate
// Beat layouts, register indexes, status codes and reset values used by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package amge_pkg;

    // Axis sample width as carried on the ports
    localparam int AXIS_W          = 16;
    // Default number of live sample bits
    localparam int SAMPLE_BITS_DEF = 16;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MAGNITUDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MAGNITUDE = 2'd2;

    // State and register widths and reset values
    localparam int FAIL_W = 4;
    localparam int EMA_W  = 18;
    localparam logic [FAIL_W-1:0] FAIL_SAT           = 4'd15;
    localparam logic [FAIL_W-1:0] FAILURE_LIMIT_RST  = 4'd3;
    localparam logic [CFG_W-1:0]  MIN_MAGNITUDE_RST  = 17'd1024;
    localparam logic [CFG_W-1:0]  MAX_MAGNITUDE_RST  = 17'd65536;
    localparam logic [EMA_W-1:0]  EMA_RST            = 18'd16384;

    // Result status codes
    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FAIL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

    // Axis select codes for the shared squarer
    localparam int AXIS_SEL_W = 2;
    localparam logic [AXIS_SEL_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_SEL_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_SEL_W-1:0] AXIS_Z = 2'd2;

    // Input beat
    typedef struct packed {
        logic                     read_ok;
        logic signed [AXIS_W-1:0] sample_x;
        logic signed [AXIS_W-1:0] sample_y;
        logic signed [AXIS_W-1:0] sample_z;
    } in_t;

    // Result beat
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [AXIS_W-1:0] x_g;
        logic signed [AXIS_W-1:0] y_g;
        logic signed [AXIS_W-1:0] z_g;
        logic [AXIS_W-1:0]        magnitude;
        logic [AXIS_W-1:0]        ema_magnitude;
        logic                     recover_bus;
    } out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic                  load;
        logic                  sq_en;
        logic [AXIS_SEL_W-1:0] sq_sel;
        logic                  root_step;
        logic                  finish;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic read_ok;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/amge_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amge_ctrl: sequencer for the magnitude gate
// Accepts a read beat; for a good read, steps the shared squarer over three
// axes and the bit-serial square root; then hands the finish command to the datapath.
// ----------------------------------------------------------------------------
module amge_ctrl #(
    parameter int SAMPLE_BITS = amge_pkg::SAMPLE_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output amge_pkg::cmd_t cmd,
    input  amge_pkg::sts_t sts
);
    import amge_pkg::*;

    localparam int CNT_W = $clog2(SAMPLE_BITS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SQR  = 2'd1;
    localparam logic [1:0] S_ROOT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             in_beat;

    assign in_stall = (state_reg != S_IDLE);
    assign in_beat  = in_valid && !in_stall;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        cmd.sq_sel    = cnt_reg[AXIS_SEL_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = sts.read_ok ? S_SQR : S_DONE;
                end
            end
            S_SQR:
            begin
                cmd.sq_en = 1'b1;
                if (cnt_reg == CNT_W'(AXIS_Z))
                begin
                    cnt_next   = '0;
                    state_next = S_ROOT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (cnt_reg == CNT_W'(SAMPLE_BITS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    // the result register is never overwritten while it still holds a beat
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> sts.out_free)
        else $error("finish issued while result register busy");

    // the last root step always leads into the finish state
    a_root_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROOT && cnt_reg == CNT_W'(SAMPLE_BITS - 1)) |=>
        state_reg == S_DONE)
        else $error("root sequence did not end in finish state");

    // a new beat is only taken in while idle
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE)
        else $error("load issued outside idle");
`endif

endmodule

// File: rtl/amge_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amge_dp: datapath for the magnitude gate
// Holds the configuration, the failure run and the EMA, squares and sums the
// axes on one shared multiplier, takes the root a bit per cycle and fills the
// result register.
// ----------------------------------------------------------------------------
module amge_dp #(
    parameter int SAMPLE_BITS = amge_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  amge_pkg::in_t                  in_data,
    input  logic                           cfg_we,
    input  logic [amge_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [amge_pkg::CFG_W-1:0]     cfg_data,
    input  amge_pkg::cmd_t                 cmd,
    output amge_pkg::sts_t                 sts,
    output logic                           out_valid,
    input  logic                           out_stall,
    output amge_pkg::out_t                 out_data
);
    import amge_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int ACC_W = 2 * SB;
    localparam int REM_W = SB + 2;

    // Configuration and state
    logic [FAIL_W-1:0] failure_limit_reg;
    logic [CFG_W-1:0]  min_magnitude_reg;
    logic [CFG_W-1:0]  max_magnitude_reg;
    logic [FAIL_W-1:0] fail_count_reg, fail_count_next;
    logic [EMA_W-1:0]  ema_reg, ema_next;

    // Working registers
    in_t               in_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [SB-1:0]     rem_reg;
    logic [SB-1:0]     root_reg;
    out_t              out_reg, out_next;
    logic              out_valid_reg;

    logic signed [SB-1:0]    ax_x, ax_y, ax_z, ax_sel;
    logic signed [ACC_W-1:0] sq_w;
    logic [REM_W-1:0]        rem_sh, trial;
    logic                    fit;
    logic [CFG_W-1:0]        mag_w;
    logic                    all_zero, reject;
    logic [FAIL_W-1:0]       fail_inc;
    logic [EMA_W+1:0]        ema3, ema_sum;

    // Axis values sign-extended from the live sample width
    assign ax_x = $signed(in_reg.sample_x[SB-1:0]);
    assign ax_y = $signed(in_reg.sample_y[SB-1:0]);
    assign ax_z = $signed(in_reg.sample_z[SB-1:0]);

    always_comb
    begin
        case (cmd.sq_sel)
            AXIS_X:  ax_sel = ax_x;
            AXIS_Y:  ax_sel = ax_y;
            AXIS_Z:  ax_sel = ax_z;
            default: ax_sel = ax_x;
        endcase
    end

    // Shared squarer
    assign sq_w = ax_sel * ax_sel;

    // One root bit per step; the remainder fits SB bits until the last step,
    // whose remainder is never read
    assign rem_sh = {rem_reg, acc_reg[ACC_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fit    = (rem_sh >= trial);

    // Gate, failure run and EMA
    assign mag_w    = CFG_W'(root_reg);
    assign all_zero = (ax_x == '0) && (ax_y == '0) && (ax_z == '0);
    assign reject   = (mag_w < min_magnitude_reg) || (mag_w > max_magnitude_reg) ||
                      all_zero;
    assign fail_inc = (fail_count_reg == FAIL_SAT) ? FAIL_SAT : fail_count_reg + 1'b1;
    assign ema3     = {2'b00, ema_reg} + {1'b0, ema_reg, 1'b0};
    assign ema_sum  = {2'b00, ema3[EMA_W+1:2]} + (EMA_W+2)'(root_reg);

    always_comb
    begin
        out_next        = '0;
        fail_count_next = fail_count_reg;
        ema_next        = ema_reg;
        if (!in_reg.read_ok)
        begin
            out_next.status = ST_FAIL;
            if (fail_inc >= failure_limit_reg)
            begin
                out_next.recover_bus = 1'b1;
                fail_count_next      = '0;
            end
            else
            begin
                fail_count_next = fail_inc;
            end
        end
        else
        begin
            fail_count_next    = '0;
            out_next.magnitude = AXIS_W'(root_reg);
            if (reject)
            begin
                out_next.status = ST_REJECT;
            end
            else
            begin
                out_next.status = ST_OK;
                out_next.x_g    = AXIS_W'(ax_x);
                out_next.y_g    = AXIS_W'(ax_y);
                out_next.z_g    = AXIS_W'(ax_z);
                ema_next        = ema_sum[EMA_W-1:0];
            end
        end
        out_next.ema_magnitude = ema_next[EMA_W-1:2];
    end

    // Working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg   <= in_data;
            acc_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sq_en)
        begin
            acc_reg <= acc_reg + $unsigned(sq_w);
        end
        else if (cmd.root_step)
        begin
            acc_reg  <= acc_reg << 2;
            rem_reg  <= fit ? SB'(rem_sh - trial) : SB'(rem_sh);
            root_reg <= {root_reg[SB-2:0], fit};
        end
        if (cmd.finish)
        begin
            out_reg <= out_next;
        end
    end

    // Configuration, state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failure_limit_reg <= FAILURE_LIMIT_RST;
            min_magnitude_reg <= MIN_MAGNITUDE_RST;
            max_magnitude_reg <= MAX_MAGNITUDE_RST;
            fail_count_reg    <= '0;
            ema_reg           <= EMA_RST;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FAILURE_LIMIT: failure_limit_reg <= cfg_data[FAIL_W-1:0];
                    CFG_MIN_MAGNITUDE: min_magnitude_reg <= cfg_data;
                    CFG_MAX_MAGNITUDE: max_magnitude_reg <= cfg_data;
                    default:           ;
                endcase
            end
            if (cmd.finish)
            begin
                fail_count_reg <= fail_count_next;
                ema_reg        <= ema_next;
                out_valid_reg  <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.read_ok  = in_data.read_ok;
    assign sts.out_free = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_reg;

`ifndef SYNTHESIS
    // finishing always presents a beat on the next cycle
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finish did not load the result register");

    // bus recovery is only requested on a failed read
    a_recover_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.recover_bus) |-> out_reg.status == ST_FAIL)
        else $error("recover_bus raised on a successful read");

    // an accepted read never has zero magnitude, since all-zero reads are rejected
    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == ST_OK) |-> out_reg.magnitude != '0)
        else $error("accepted read with zero magnitude");

    // status is one of the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.status == ST_OK || out_reg.status == ST_FAIL ||
                           out_reg.status == ST_REJECT))
        else $error("undefined status code");
`endif

endmodule

// File: rtl/accel_magnitude_gate_ema_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_magnitude_gate_ema_core: accelerometer magnitude gate with EMA
// Counts failed reads and requests bus recovery, takes the vector magnitude
// of good reads, rejects implausible ones and smooths the rest (alpha 1/4).
// ----------------------------------------------------------------------------
//  channel | handshake            | beat
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_stall  | in_data: read_ok, sample_x/y/z
//  out     | out_valid / out_stall| out_data: status, x/y/z_g, magnitude, ...
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  A good read steps through accept, three squarer passes on the shared
//  multiplier, one root bit per cycle and finish; a failed read goes from
//  accept to finish. One read is in flight at a time; the next is accepted
//  as soon as the result sits in the output register. rst_n clears the
//  sequencer, the failure run and the valid flag, and presets the EMA and
//  config registers. A stalled result holds finish until the output frees up.
// ----------------------------------------------------------------------------
module accel_magnitude_gate_ema_core #(
    parameter int SAMPLE_BITS = amge_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  amge_pkg::in_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output amge_pkg::out_t                 out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [amge_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [amge_pkg::CFG_W-1:0]     cfg_data
);
    import amge_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Registers take a write on any cycle
    assign cfg_ready = 1'b1;

    amge_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    amge_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: test/accel_magnitude_gate_ema_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_magnitude_gate_ema_core_test: self-checking bench for the magnitude gate
// A directed plan covers the failure counter, the recovery pulse, the
// plausibility window and the register port. Random phases with fresh
// register settings follow. Every result beat is checked field by field
// against a fixed expected beat or an in-bench model of the gate and smoothing
// filter, with random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module accel_magnitude_gate_ema_core_test;

    import amge_pkg::*;

    localparam int PHASES        = 12;
    localparam int PHASE_READS   = 100;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_AFTER    = 450;
    localparam int HOLD_CYCLES   = 500;
    localparam int IN_W          = $bits(in_t);
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic {ROW_READ, ROW_WRITE} row_kind_t;

    // one step of the directed plan
    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_W-1:0]       reg_val;
        in_t                    beat;
        logic                   typed;
        out_t                   want;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_t                  in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_t                 out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // model copy of registers and state
    logic [FAIL_W-1:0] fail_limit;
    logic [CFG_W-1:0]  mag_floor;
    logic [CFG_W-1:0]  mag_ceiling;
    logic [FAIL_W-1:0] miss_run;
    logic [EMA_W-1:0]  smoothed;

    out_t awaited_results[$];
    row_t plan[$];
    int   mismatch_count = 0;
    int   results_seen   = 0;
    int   idle_cycles    = 0;
    bit   held_off       = 0;
    bit   sender_calm    = 0;

    accel_magnitude_gate_ema_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
    end

    // floor square root, one result bit per pass
    function automatic logic [16:0] floor_root(input longint n);
        logic [16:0] r;
        logic [16:0] t;
        r = '0;
        for (int b = 16; b >= 0; b--)
        begin
            t = r | (17'd1 << b);
            if (longint'(t) * longint'(t) <= n)
                r = t;
        end
        return r;
    endfunction

    // gate one read attempt and advance the failure run and the filter
    task automatic gate_reading(input in_t beat, output out_t res);
        longint           sx;
        longint           sy;
        longint           sz;
        logic [16:0]      root;
        logic [EMA_W+1:0] tripled;
        res = '0;
        if (!beat.read_ok)
        begin
            res.status = ST_FAIL;
            if (miss_run != FAIL_SAT)
                miss_run = miss_run + 1'b1;
            if (miss_run >= fail_limit)
            begin
                res.recover_bus = 1'b1;
                miss_run        = '0;
            end
        end
        else
        begin
            miss_run      = '0;
            sx            = $signed(beat.sample_x);
            sy            = $signed(beat.sample_y);
            sz            = $signed(beat.sample_z);
            root          = floor_root(sx * sx + sy * sy + sz * sz);
            res.magnitude = root[15:0];
            if (root < mag_floor || root > mag_ceiling || (sx == 0 && sy == 0 && sz == 0))
                res.status = ST_REJECT;
            else
            begin
                res.status = ST_OK;
                res.x_g    = beat.sample_x;
                res.y_g    = beat.sample_y;
                res.z_g    = beat.sample_z;
                tripled    = {2'b00, smoothed} + {1'b0, smoothed, 1'b0};
                smoothed   = EMA_W'((EMA_W+2)'(root) + (tripled >> 2));
            end
        end
        res.ema_magnitude = smoothed[EMA_W-1:2];
    endtask

    function automatic out_t fixed_result(input logic [STATUS_W-1:0] st, input int x,
                                          input int y, input int z, input int mag,
                                          input int ema, input logic rec);
        out_t r;
        r.status        = st;
        r.x_g           = x[AXIS_W-1:0];
        r.y_g           = y[AXIS_W-1:0];
        r.z_g           = z[AXIS_W-1:0];
        r.magnitude     = mag[AXIS_W-1:0];
        r.ema_magnitude = ema[AXIS_W-1:0];
        r.recover_bus   = rec;
        return r;
    endfunction

    function automatic row_t read_row(input logic ok, input int x, input int y, input int z,
                                      input logic typed = 1'b0, input out_t want = '0);
        row_t r;
        r               = '0;
        r.kind          = ROW_READ;
        r.beat.read_ok  = ok;
        r.beat.sample_x = x[AXIS_W-1:0];
        r.beat.sample_y = y[AXIS_W-1:0];
        r.beat.sample_z = z[AXIS_W-1:0];
        r.typed         = typed;
        r.want          = want;
        return r;
    endfunction

    function automatic row_t write_row(input logic [CFG_IDX_W-1:0] idx, input int val);
        row_t r;
        r         = '0;
        r.kind    = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = val[CFG_W-1:0];
        return r;
    endfunction

    function automatic logic signed [AXIS_W-1:0] draw_axis(input int mode);
        case (mode)
            0:       return AXIS_W'($urandom);
            1:       return AXIS_W'($urandom_range(0, 8192) - 4096);
            2:       return AXIS_W'($urandom_range(0, 2048) - 1024);
            default: return '0;
        endcase
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // offer one input beat, then log what it should produce
    task automatic offer_reading(input in_t beat, input logic typed, input out_t want);
        int   pick;
        int   gap;
        out_t res;
        pick = $urandom_range(0, 99);
        if (sender_calm || pick < 60)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        gate_reading(beat, res);
        awaited_results.push_back(typed ? want : res);
    endtask

    // stop offering and wait for every awaited result
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_FAILURE_LIMIT: fail_limit  = val[FAIL_W-1:0];
            CFG_MIN_MAGNITUDE: mag_floor   = val;
            CFG_MAX_MAGNITUDE: mag_ceiling = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: short stalls, calm stretches, rare long ones and one long hold-off
    initial
    begin
        int   pick;
        int   span;
        logic hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            pick = $urandom_range(0, 99);
            if (!held_off && results_seen >= HOLD_AFTER)
            begin
                held_off = 1;
                hold     = 1'b1;
                span     = HOLD_CYCLES;
            end
            else if (pick < 15)
            begin
                hold = 1'b0;
                span = $urandom_range(40, 120);
            end
            else if (pick < 25)
            begin
                hold = 1'b1;
                span = $urandom_range(10, 40);
            end
            else
            begin
                hold = 1'($urandom_range(0, 1));
                span = $urandom_range(1, 4);
            end
            repeat (span)
            begin
                @(negedge clk);
                out_stall <= hold;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (awaited_results.size() == 0)
            begin
                $error("result beat arrived with nothing awaited");
                mismatch_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("status", want.status, out_data.status);
                check_field("x_g", $signed(want.x_g), $signed(out_data.x_g));
                check_field("y_g", $signed(want.y_g), $signed(out_data.y_g));
                check_field("z_g", $signed(want.z_g), $signed(out_data.z_g));
                check_field("magnitude", want.magnitude, out_data.magnitude);
                check_field("ema_magnitude", want.ema_magnitude, out_data.ema_magnitude);
                check_field("recover_bus", want.recover_bus, out_data.recover_bus);
            end
        end
    end

    // watchdog on cycles with no beat moving on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("accel_magnitude_gate_ema_core test failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int   left;
        int   run;
        int   mode;
        int   pick;
        in_t  beat;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_FAILURE_LIMIT;
        cfg_data    = '0;
        fail_limit  = FAILURE_LIMIT_RST;
        mag_floor   = MIN_MAGNITUDE_RST;
        mag_ceiling = MAX_MAGNITUDE_RST;
        miss_run    = '0;
        smoothed    = EMA_RST;

        // directed plan at reset settings: failure run up to the limit
        plan.push_back(read_row(0, 0, 0, 0, 1, fixed_result(ST_FAIL, 0, 0, 0, 0, 4096, 0)));
        plan.push_back(read_row(0, -1, 1, -1, 1, fixed_result(ST_FAIL, 0, 0, 0, 0, 4096, 0)));
        plan.push_back(read_row(0, 7, 7, 7, 1, fixed_result(ST_FAIL, 0, 0, 0, 0, 4096, 1)));
        // all axes zero, then exactly one g, then the most negative and most positive corners
        plan.push_back(read_row(1, 0, 0, 0, 1, fixed_result(ST_REJECT, 0, 0, 0, 0, 4096, 0)));
        plan.push_back(read_row(1, 4096, 0, 0, 1,
                                fixed_result(ST_OK, 4096, 0, 0, 4096, 4096, 0)));
        plan.push_back(read_row(1, -32768, -32768, -32768, 1,
                                fixed_result(ST_OK, -32768, -32768, -32768, 56755, 17260, 0)));
        plan.push_back(read_row(1, 32767, 32767, 32767));
        // either side of the lower bound
        plan.push_back(read_row(1, 1023, 0, 0));
        plan.push_back(read_row(1, 0, 0, -1024));
        plan.push_back(read_row(1, 0, -1, 0));
        // a good read breaks the failure run
        plan.push_back(read_row(0, 0, 0, 0));
        plan.push_back(read_row(1, 3000, -2000, 1500));
        plan.push_back(read_row(0, 0, 0, 0));
        plan.push_back(read_row(0, 0, 0, 0));
        plan.push_back(read_row(1, 16'h5555, 16'hAAAA, 16'h7FFF));
        // limit of zero: every failure recovers
        plan.push_back(write_row(CFG_FAILURE_LIMIT, 0));
        plan.push_back(read_row(0, 0, 0, 0));
        plan.push_back(read_row(0, 0, 0, 0));
        // limit lowered below a run already counted
        plan.push_back(write_row(CFG_FAILURE_LIMIT, 15));
        repeat (5) plan.push_back(read_row(0, 1, 2, 3));
        plan.push_back(write_row(CFG_FAILURE_LIMIT, 2));
        plan.push_back(read_row(0, 0, 0, 0));
        // empty window: floor above ceiling
        plan.push_back(write_row(CFG_MIN_MAGNITUDE, 131071));
        plan.push_back(write_row(CFG_MAX_MAGNITUDE, 0));
        plan.push_back(read_row(1, 4096, 0, 0));
        // widest window, and a write to the spare index that must do nothing
        plan.push_back(write_row(CFG_MIN_MAGNITUDE, 0));
        plan.push_back(write_row(CFG_MAX_MAGNITUDE, 131071));
        plan.push_back(write_row(CFG_SPARE, 131071));
        plan.push_back(read_row(1, -1, 0, 0));
        plan.push_back(read_row(1, 0, 0, 0));

        @(posedge rst_n);
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                drain();
                write_register(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                offer_reading(plan[i].beat, plan[i].typed, plan[i].want);
        end

        // random phases, each with its own register settings
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            pick = $urandom_range(0, 3);
            write_register(CFG_FAILURE_LIMIT,
                           CFG_W'(pick == 0 ? 0 : pick == 1 ? 1 : pick == 2 ? 15 :
                                  $urandom_range(0, 15)));
            pick = $urandom_range(0, 7);
            write_register(CFG_MIN_MAGNITUDE,
                           CFG_W'(pick == 0 ? 0 : pick == 1 ? 131071 :
                                  $urandom_range(0, 4096)));
            pick = $urandom_range(0, 7);
            write_register(CFG_MAX_MAGNITUDE,
                           CFG_W'(pick == 0 ? 131071 : pick == 1 ? 0 : pick == 2 ? 65536 :
                                  $urandom_range(8192, 131071)));
            if ($urandom_range(0, 3) == 0)
                write_register(CFG_SPARE, CFG_W'($urandom));
            sender_calm = ($urandom_range(0, 3) == 0);
            left = PHASE_READS;
            while (left > 0)
            begin
                // failure runs of varying length, otherwise good reads
                if ($urandom_range(0, 99) < 25)
                    run = $urandom_range(1, 17);
                else
                    run = 1;
                mode = (run > 1) ? -1 : $urandom_range(0, 3);
                for (int k = 0; k < run && left > 0; k++)
                begin
                    beat = in_t'(IN_W'({$urandom, $urandom}));
                    if (mode >= 0)
                    begin
                        beat.read_ok  = 1'b1;
                        beat.sample_x = draw_axis($urandom_range(0, 5) == 0 ? 3 : mode);
                        beat.sample_y = draw_axis($urandom_range(0, 5) == 0 ? 3 : mode);
                        beat.sample_z = draw_axis($urandom_range(0, 5) == 0 ? 3 : mode);
                    end
                    else
                        beat.read_ok = 1'b0;
                    offer_reading(beat, 1'b0, '0);
                    left--;
                end
            end
        end

        // wind down
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            $error("awaited_results: expected 0 left, got %0d", awaited_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("accel_magnitude_gate_ema_core test passed");
        else
            $display("accel_magnitude_gate_ema_core test failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/amge_pkg.sv
rtl/amge_ctrl.sv
rtl/amge_dp.sv
rtl/accel_magnitude_gate_ema_core.sv
test/accel_magnitude_gate_ema_core_test.sv
